// ===== hdl/mars_pkg.sv =====
// Package: codes, phase type and constant tables for the modem answer sequencer.
`default_nettype none

package mars_pkg;

    typedef enum logic [2:0] {
        PH_WAIT = 3'd0,
        PH_HUNT = 3'd1,
        PH_SKIP = 3'd2,
        PH_LINE = 3'd3,
        PH_CONN = 3'd4
    } t_phase;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_ANSWER    = 3'd1,
        ACT_CONNECTED = 3'd2,
        ACT_BAD_SPEED = 3'd3,
        ACT_TIMEOUT   = 3'd4,
        ACT_NO_CARR   = 3'd5
    } t_action;

    localparam logic [1:0] KIND_RING = 2'd0;
    localparam logic [1:0] KIND_BYTE = 2'd1;
    localparam logic [1:0] KIND_TICK = 2'd2;

    localparam logic [7:0]  TIMEOUT_RESET = 8'd90;
    localparam logic [15:0] RATE_DEFAULT  = 16'd300;
    localparam logic [6:0]  CH_LF    = 7'h0A;
    localparam logic [6:0]  CH_CR    = 7'h0D;
    localparam logic [6:0]  CH_SPACE = 7'h20;
    localparam logic [6:0]  CH_0     = 7'h30;
    localparam logic [6:0]  CH_9     = 7'h39;
    localparam logic [6:0]  CH_A     = 7'h41;
    localparam logic [6:0]  CH_Z     = 7'h5A;

    // "CONNECT", one character per position
    function automatic logic [6:0] connect_char(input logic [2:0] i);
        logic [6:0] c;
        case (i)
            3'd0:    c = 7'h43; // C
            3'd1:    c = 7'h4F; // O
            3'd2:    c = 7'h4E; // N
            3'd3:    c = 7'h4E; // N
            3'd4:    c = 7'h45; // E
            3'd5:    c = 7'h43; // C
            3'd6:    c = 7'h54; // T
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // "NO CARRIER", one character per position
    function automatic logic [6:0] nocarr_char(input logic [3:0] i);
        logic [6:0] c;
        case (i)
            4'd0:    c = 7'h4E; // N
            4'd1:    c = 7'h4F; // O
            4'd2:    c = 7'h20; // space
            4'd3:    c = 7'h43; // C
            4'd4:    c = 7'h41; // A
            4'd5:    c = 7'h52; // R
            4'd6:    c = 7'h52; // R
            4'd7:    c = 7'h49; // I
            4'd8:    c = 7'h45; // E
            4'd9:    c = 7'h52; // R
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    // Legal speeds pass, speeds above 4800 up to 38400 round up, any other speed gives zero (hang up)
    function automatic logic [15:0] pick_rate(input logic [15:0] s);
        logic [15:0] r;
        if (s == 16'd300 || s == 16'd600 || s == 16'd1200 || s == 16'd2400 ||
            s == 16'd4800 || s == 16'd9600) begin
            r = s;
        end else if (s > 16'd4800 && s < 16'd9600) begin
            r = 16'd9600;
        end else if (s > 16'd9600 && s <= 16'd19200) begin
            r = 16'd19200;
        end else if (s > 16'd19200 && s <= 16'd38400) begin
            r = 16'd38400;
        end else begin
            r = 16'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/modem_answer_response_sequencer_core.sv =====
// Top level: modem answer and response line sequencer with registered result stage.
// Usage
//   Slave stream carries one event per transfer: tuser = kind (ring sample,
//   received byte, one-second tick), tdata = ring level and received byte.
//   Master stream returns exactly one result per event: tuser = action,
//   tdata = chosen line rate and the phase after the event.
//   The configuration channel writes the answer timeout (second ticks) and is
//   always ready; the user must write it only while idle, the block does not check.
// Timing
//   A result is valid in the cycle after its event is accepted; throughput is one
//   event per cycle while results are taken. State update and result decode are a
//   single combinational pass from the event into the state and result registers.
// Stall
//   The result register is freed in the cycle it is taken, so s_axis_tready
//   stays high while the receiver accepts; when the receiver stalls with a
//   result pending, s_axis_tready drops and the state holds.
// Reset
//   Synchronous, active low: phase returns to ring wait, all line tracking
//   is cleared, the timeout is set to 90 and no result is pending.
//   Once connected the block stays connected until reset.
`default_nettype none

module modem_answer_response_sequencer_core #(
    parameter int LINE_KEEP = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,

    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // [0] ring_active, [8:1] rx_byte, [15:9] zero
    input  wire logic [1:0]  s_axis_tuser,  // [1:0] kind

    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // [15:0] line_rate, [18:16] phase_now, [23:19] zero
    output logic [2:0]       m_axis_tuser,  // [2:0] action

    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [7:0]  i_cfg_data
);
    import mars_pkg::*;

    // enough bits to count up to LINE_KEEP-1 kept characters
    localparam int LW = $clog2(LINE_KEEP);
    localparam logic [LW-1:0] POS_LIMIT = LW'(LINE_KEEP - 1);

    // ---- state ----
    t_phase        r_phase, n_phase;
    logic [LW-1:0] r_pos, n_pos;
    logic          r_conn_ok, n_conn_ok;
    logic          r_noc_ok, n_noc_ok;
    logic          r_live, n_live;
    logic          r_seen, n_seen;
    logic [15:0]   r_speed, n_speed;
    logic [7:0]    r_secs, n_secs;
    logic [7:0]    r_timeout;

    // ---- result register ----
    logic          r_out_valid;
    t_action       r_out_act;
    logic [15:0]   r_out_rate;
    t_phase        r_out_phase;

    t_action       n_act;
    logic [15:0]   n_rate;

    logic          s_fire;
    logic [1:0]    kind;
    logic          ring;
    logic [6:0]    ch;
    logic          is_digit;
    logic [3:0]    digit;
    logic          collecting;

    // line tracking base: fresh for a line start, else current
    logic [LW-1:0] b_pos;
    logic          b_conn_ok, b_noc_ok, b_live, b_seen;
    logic [15:0]   b_speed;
    // after keeping the current character
    logic [LW-1:0] k_pos;
    logic          k_conn_ok, k_noc_ok, k_live, k_seen;
    logic [15:0]   k_speed;
    logic [19:0]   acc;
    logic [15:0]   conn_rate;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready   = 1'b1;

    assign kind     = s_axis_tuser;
    assign ring     = s_axis_tdata[0];
    assign ch       = s_axis_tdata[7:1];  // rx_byte masked to 7 bits
    assign is_digit = (ch >= CH_0) && (ch <= CH_9);
    assign digit    = 4'(ch - CH_0);
    assign collecting = (r_phase == PH_HUNT) || (r_phase == PH_SKIP) ||
                        (r_phase == PH_LINE);

    // speed accumulator, saturating at 16 bits
    assign acc = ({4'd0, b_speed} << 3) + ({4'd0, b_speed} << 1) + {16'd0, digit};

    always_comb begin
        if (r_phase == PH_SKIP) begin
            b_pos     = '0;
            b_conn_ok = 1'b1;
            b_noc_ok  = 1'b1;
            b_live    = 1'b0;
            b_seen    = 1'b0;
            b_speed   = 16'd0;
        end else begin
            b_pos     = r_pos;
            b_conn_ok = r_conn_ok;
            b_noc_ok  = r_noc_ok;
            b_live    = r_live;
            b_seen    = r_seen;
            b_speed   = r_speed;
        end

        k_pos     = b_pos;
        k_conn_ok = b_conn_ok;
        k_noc_ok  = b_noc_ok;
        k_live    = b_live;
        k_seen    = b_seen;
        k_speed   = b_speed;
        if (b_pos < POS_LIMIT) begin
            if (b_pos < LW'(7) && ch != connect_char(b_pos[2:0])) begin
                k_conn_ok = 1'b0;
            end
            if (b_pos >= LW'(10) || ch != nocarr_char(b_pos[3:0])) begin
                k_noc_ok = 1'b0;
            end
            if (b_pos == LW'(7)) begin
                k_live = (ch == CH_SPACE);
            end else if (b_pos == LW'(8)) begin
                if (b_live && is_digit) begin
                    k_seen  = 1'b1;
                    k_speed = {12'd0, digit};
                end else begin
                    k_live = 1'b0;
                end
            end else if (b_pos > LW'(8)) begin
                if (b_live && is_digit) begin
                    k_speed = (acc > 20'd65535) ? 16'hFFFF : acc[15:0];
                end else begin
                    k_live = 1'b0;
                end
            end
            k_pos = b_pos + LW'(1);
        end
    end

    assign conn_rate = pick_rate(r_seen ? r_speed : RATE_DEFAULT);

    // next state and result for the event at the slave port
    always_comb begin
        n_phase   = r_phase;
        n_pos     = r_pos;
        n_conn_ok = r_conn_ok;
        n_noc_ok  = r_noc_ok;
        n_live    = r_live;
        n_seen    = r_seen;
        n_speed   = r_speed;
        n_secs    = r_secs;
        n_act     = ACT_NONE;
        n_rate    = 16'd0;

        if (r_phase == PH_WAIT) begin
            if (kind == KIND_RING && ring) begin
                n_act   = ACT_ANSWER;
                n_phase = PH_HUNT;
                n_secs  = 8'd0;
            end
        end else if (collecting && kind == KIND_TICK) begin
            n_secs = (r_secs == 8'hFF) ? r_secs : r_secs + 8'd1;
            if (n_secs >= r_timeout) begin
                n_act   = ACT_TIMEOUT;
                n_phase = PH_WAIT;
            end
        end else if (collecting && kind == KIND_BYTE) begin
            unique case (r_phase)
                PH_HUNT: begin
                    if (ch == CH_LF) n_phase = PH_SKIP;
                end
                PH_SKIP: begin
                    if (ch == CH_LF) begin
                        n_phase = PH_SKIP;
                    end else if (ch >= CH_A && ch <= CH_Z) begin
                        n_pos     = k_pos;
                        n_conn_ok = k_conn_ok;
                        n_noc_ok  = k_noc_ok;
                        n_live    = k_live;
                        n_seen    = k_seen;
                        n_speed   = k_speed;
                        n_phase   = PH_LINE;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
                PH_LINE: begin
                    if (ch == CH_CR || ch == CH_LF) begin
                        if (r_conn_ok && r_pos >= LW'(7)) begin
                            if (conn_rate != 16'd0) begin
                                n_act   = ACT_CONNECTED;
                                n_rate  = conn_rate;
                                n_phase = PH_CONN;
                            end else begin
                                n_act   = ACT_BAD_SPEED;
                                n_phase = PH_WAIT;
                            end
                        end else if (r_noc_ok && r_pos == LW'(10)) begin
                            n_act   = ACT_NO_CARR;
                            n_phase = PH_WAIT;
                        end else begin
                            n_phase = PH_HUNT;
                        end
                    end else begin
                        n_pos     = k_pos;
                        n_conn_ok = k_conn_ok;
                        n_noc_ok  = k_noc_ok;
                        n_live    = k_live;
                        n_seen    = k_seen;
                        n_speed   = k_speed;
                    end
                end
                default: n_phase = r_phase;
            endcase
        end
    end

    // state registers, stepped only on an accepted event
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_WAIT;
            r_pos     <= '0;
            r_conn_ok <= 1'b0;
            r_noc_ok  <= 1'b0;
            r_live    <= 1'b0;
            r_seen    <= 1'b0;
            r_speed   <= 16'd0;
            r_secs    <= 8'd0;
        end else if (s_fire) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_conn_ok <= n_conn_ok;
            r_noc_ok  <= n_noc_ok;
            r_live    <= n_live;
            r_seen    <= n_seen;
            r_speed   <= n_speed;
            r_secs    <= n_secs;
        end
    end

    // timeout register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= TIMEOUT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_timeout <= i_cfg_data;
        end
    end

    // result register; valid bit only is reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_out_act   <= n_act;
            r_out_rate  <= n_rate;
            r_out_phase <= n_phase;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_act;
    assign m_axis_tdata  = {5'd0, r_out_phase, r_out_rate};

`ifndef ASSERT_OFF
    // a connected result always carries a nonzero rate and the connected phase
    a_conn_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_act == ACT_CONNECTED) |->
        (r_out_rate != 16'd0 && r_out_phase == PH_CONN))
        else $error("connected result without rate or phase");

    // rate is only reported with a connection
    a_rate_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_act != ACT_CONNECTED) |-> (r_out_rate == 16'd0))
        else $error("line rate set without connection");

    // connected phase is sticky until reset
    a_conn_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_CONN) |=> (r_phase == PH_CONN))
        else $error("left connected phase");

    // a pending result that is not taken holds its contents
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=>
        (r_out_valid && $stable(r_out_act) && $stable(r_out_rate) &&
         $stable(r_out_phase)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

// ===== sim/modem_answer_response_sequencer_core_tb.sv =====
// Testbench: directed and random event streams for the modem answer sequencer core.
module modem_answer_response_sequencer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mars_pkg::*;

    localparam int         LINE_KEEP   = 64;
    localparam logic [1:0] KIND_SPARE  = 2'd3;   // unused kind, must be ignored
    localparam int         IDLE_PCT    = 29;
    localparam int         HOLD_CYCLES = 300;

    typedef struct {
        t_action     act;
        logic [15:0] rate;
        t_phase      ph;
    } t_answer_result;

    // ---------------------------------------------------------------- DUT I/O
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // [0] ring_active, [8:1] rx_byte, [15:9] zero
    logic [1:0]  s_axis_tuser  = '0;   // [1:0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;         // [15:0] line_rate, [18:16] phase_now, [23:19] zero
    logic [2:0]  m_axis_tuser;         // [2:0] action
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = '0;

    modem_answer_response_sequencer_core #(
        .LINE_KEEP(LINE_KEEP)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------- shared tb state
    t_answer_result pending_results[$];
    int             errors        = 0;
    int             useful_items  = 0;   // transfers in a collecting phase, or rings answered
    bit             steady        = 1'b0; // no idling on either side
    bit             hold_request  = 1'b0; // receiver long hold-off
    int             hold_left     = 0;

    // Sequencer mirror
    t_phase      ph_m    = PH_WAIT;
    int          pos_m   = 0;
    bit          pref_m  = 1'b0;
    bit          nc_m    = 1'b0;
    bit          live_m  = 1'b0;
    bit          seen_m  = 1'b0;
    int          speed_m = 0;
    int          secs_m  = 0;
    logic [7:0]  tmo_m   = TIMEOUT_RESET;

    string connect_word = "CONNECT";
    string nocarr_word  = "NO CARRIER";

    // ------------------------------------------------------------- predictor
    function automatic int rate_for_speed(input int s);
        if (s == 300 || s == 600 || s == 1200 || s == 2400 || s == 4800 || s == 9600)
            return s;
        if (s > 4800 && s < 9600)
            return 9600;
        if (s > 9600 && s <= 19200)
            return 19200;
        if (s > 19200 && s <= 38400)
            return 38400;
        return 0;
    endfunction

    // Track one kept character of a response line
    task automatic keep_char(input logic [6:0] c);
        byte w;
        bit  dig;
        dig = (c >= CH_0 && c <= CH_9);
        if (pos_m >= LINE_KEEP - 1)
            return;
        if (pos_m < 7) begin
            w = connect_word[pos_m];
            if (c != w[6:0])
                pref_m = 1'b0;
        end
        if (pos_m >= 10) begin
            nc_m = 1'b0;
        end else begin
            w = nocarr_word[pos_m];
            if (c != w[6:0])
                nc_m = 1'b0;
        end
        if (pos_m == 7) begin
            live_m = (c == CH_SPACE);
        end else if (pos_m == 8) begin
            if (live_m && dig) begin
                seen_m  = 1'b1;
                speed_m = int'(c - CH_0);
            end else begin
                live_m = 1'b0;
            end
        end else if (pos_m > 8) begin
            if (live_m && dig) begin
                speed_m = speed_m * 10 + int'(c - CH_0);
                if (speed_m > 65535)
                    speed_m = 65535;
            end else begin
                live_m = 1'b0;
            end
        end
        pos_m++;
    endtask

    // Advance the mirror by one accepted event and queue the result it gives
    task automatic predict_response(input logic [1:0] kind, input logic ring,
                                    input logic [7:0] rxb);
        t_answer_result r;
        logic [6:0]     c;
        bit             busy;
        int             rt;
        c      = rxb[6:0];
        r.act  = ACT_NONE;
        r.rate = '0;
        busy   = (ph_m == PH_HUNT || ph_m == PH_SKIP || ph_m == PH_LINE);
        if (busy || (ph_m == PH_WAIT && kind == KIND_RING && ring))
            useful_items++;
        if (ph_m == PH_WAIT) begin
            if (kind == KIND_RING && ring) begin
                r.act  = ACT_ANSWER;
                ph_m   = PH_HUNT;
                secs_m = 0;
            end
        end else if (busy && kind == KIND_TICK) begin
            if (secs_m < 255)
                secs_m++;
            if (secs_m >= tmo_m) begin
                r.act = ACT_TIMEOUT;
                ph_m  = PH_WAIT;
            end
        end else if (busy && kind == KIND_BYTE) begin
            case (ph_m)
                PH_HUNT: begin
                    if (c == CH_LF)
                        ph_m = PH_SKIP;
                end
                PH_SKIP: begin
                    if (c != CH_LF) begin
                        if (c >= CH_A && c <= CH_Z) begin
                            pos_m   = 0;
                            pref_m  = 1'b1;
                            nc_m    = 1'b1;
                            live_m  = 1'b0;
                            seen_m  = 1'b0;
                            speed_m = 0;
                            keep_char(c);
                            ph_m    = PH_LINE;
                        end else begin
                            ph_m = PH_HUNT;
                        end
                    end
                end
                default: begin
                    if (c == CH_CR || c == CH_LF) begin
                        if (pref_m && pos_m >= 7) begin
                            rt = rate_for_speed(seen_m ? speed_m : 300);
                            if (rt != 0) begin
                                r.act  = ACT_CONNECTED;
                                r.rate = rt[15:0];
                                ph_m   = PH_CONN;
                            end else begin
                                r.act = ACT_BAD_SPEED;
                                ph_m  = PH_WAIT;
                            end
                        end else if (nc_m && pos_m == 10) begin
                            r.act = ACT_NO_CARR;
                            ph_m  = PH_WAIT;
                        end else begin
                            ph_m = PH_HUNT;
                        end
                    end else begin
                        keep_char(c);
                    end
                end
            endcase
        end
        r.ph = ph_m;
        pending_results.push_back(r);
    endtask

    // ---------------------------------------------------------- result side
    task automatic note_mismatch(input string what, input int e, input int a);
        errors++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, e, a);
    endtask

    // Receiver: random idling, a long hold-off on request, none when steady
    always @(negedge i_clk) begin
        if (hold_request) begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_answer_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                note_mismatch("unexpected result, action", -1, m_axis_tuser);
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tuser !== exp_r.act)
                    note_mismatch("action", exp_r.act, m_axis_tuser);
                if (m_axis_tdata[15:0] !== exp_r.rate)
                    note_mismatch("line_rate", exp_r.rate, m_axis_tdata[15:0]);
                if (m_axis_tdata[18:16] !== exp_r.ph)
                    note_mismatch("phase_now", exp_r.ph, m_axis_tdata[18:16]);
            end
        end
    end

    // ------------------------------------------------------------ stimulus
    // One event transfer; entered and left at a falling edge
    task automatic send_event(input logic [1:0] kind, input logic ring,
                              input logic [7:0] rxb);
        while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {7'd0, rxb, ring};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        predict_response(kind, ring, rxb);
        @(negedge i_clk);
    endtask

    // Received byte; the ignored top bit and ring level are random
    task automatic send_char(input logic [6:0] c);
        logic       r;
        logic [7:0] b;
        r    = 1'($urandom_range(0, 1));
        b    = {1'b0, c};
        b[7] = 1'($urandom_range(0, 1));
        send_event(KIND_BYTE, r, b);
    endtask

    task automatic send_tick();
        logic       r;
        logic [7:0] b;
        r = 1'($urandom_range(0, 1));
        b = 8'($urandom_range(0, 255));
        send_event(KIND_TICK, r, b);
    endtask

    // Any kind, random content
    task automatic send_noise();
        logic [1:0] k;
        logic       r;
        logic [7:0] b;
        k = 2'($urandom_range(0, 3));
        r = 1'($urandom_range(0, 1));
        b = 8'($urandom_range(0, 255));
        send_event(k, r, b);
    endtask

    task automatic send_text(input string s, input int tick_pct);
        byte ch;
        for (int i = 0; i < s.len(); i++) begin
            if ($urandom_range(0, 99) < tick_pct)
                send_tick();
            if ($urandom_range(0, 99) < 3)
                send_noise();
            ch = s[i];
            send_char(ch[6:0]);
        end
    endtask

    function automatic string random_text(input int n);
        string s;
        s = "";
        repeat (n)
            s = $sformatf("%s%c", s, $urandom_range(32, 126));
        return s;
    endfunction

    // Speed digits that the rate rule always rejects
    function automatic string bad_speed_digits();
        string s;
        int    v;
        case ($urandom_range(0, 3))
            0: begin
                v = $urandom_range(0, 4799);
                while (rate_for_speed(v) != 0)
                    v = $urandom_range(0, 4799);
                s = $sformatf("%0d", v);
            end
            1: s = $sformatf("%0d", $urandom_range(38401, 65535));
            2: begin
                // six digits or more: accumulator saturates
                s = $sformatf("%0d", $urandom_range(1, 9));
                repeat ($urandom_range(5, 11))
                    s = $sformatf("%s%0d", s, $urandom_range(0, 9));
            end
            default: begin
                s = "0";
                repeat ($urandom_range(0, 4))
                    s = {s, "0"};
            end
        endcase
        return s;
    endfunction

    // One response line without its terminator; never a good connect
    function automatic string build_line();
        string s;
        string starters;
        byte   ch;
        starters = "az09@[ ~";
        case ($urandom_range(0, 9))
            0, 1: s = "NO CARRIER";
            2, 3: begin
                s = {"CONNECT ", bad_speed_digits()};
                if ($urandom_range(0, 1))
                    s = {s, "/ARQ"};
            end
            4: begin
                // digits run past the kept width, so only a prefix of 1200 counts
                s = "CONNECT ";
                repeat ($urandom_range(52, 56))
                    s = {s, "0"};
                s = {s, "1200"};
            end
            5: begin
                case ($urandom_range(0, 7))
                    0: s = "CONNEC";
                    1: s = "CONNEXT 2400";
                    2: s = "NO CARRIE";
                    3: s = "NO CARRIERS";
                    4: s = "NO CARRIER ";
                    5: s = {"NO CARRIER", random_text($urandom_range(1, 60))};
                    6: s = "BUSY";
                    default: s = "RING";
                endcase
            end
            6: begin
                // first character not an uppercase letter
                ch = starters[$urandom_range(0, 7)];
                s  = $sformatf("%c%s", ch, random_text($urandom_range(0, 8)));
            end
            default: s = $sformatf("%c%s", $urandom_range(65, 90),
                                   random_text($urandom_range(0, 70)));
        endcase
        return s;
    endfunction

    // Drop valid, let all results drain, then a few spare cycles
    task automatic wait_quiet();
        int spin;
        s_axis_tvalid <= 1'b0;
        spin = 0;
        while (pending_results.size() != 0 && spin < 2000) begin
            @(negedge i_clk);
            spin++;
        end
        repeat (4) @(negedge i_clk);
    endtask

    task automatic set_answer_timeout(input logic [7:0] v);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        tmo_m = v;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        repeat (2) @(negedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests
    // Out-of-place events in ring wait, then the answer and a stray ring
    task automatic test_wait_ring_ignores();
        send_event(KIND_BYTE, 1'b0, 8'h0A);
        send_event(KIND_TICK, 1'b1, 8'hFF);
        send_event(KIND_SPARE, 1'b1, 8'h80);
        send_event(KIND_RING, 1'b0, 8'h00);
        send_event(KIND_RING, 1'b1, 8'hFF);
        send_event(KIND_RING, 1'b1, 8'h00);
        send_event(KIND_SPARE, 1'b0, 8'h7F);
    endtask

    // Hunting, skipped newlines, bad first characters and NO CARRIER
    task automatic test_line_hunting();
        send_char(CH_A);
        send_char(CH_LF);
        send_char(CH_LF);
        send_char(CH_Z + 7'd1);
        send_event(KIND_BYTE, 1'b0, 8'h8A);   // LF with the top bit set
        send_char(CH_A - 7'd1);
        send_char(CH_LF);
        send_text("NO CARRIER", 0);
        send_char(CH_CR);
    endtask

    // Shortest timeouts, zero included
    task automatic test_timeout_edges();
        set_answer_timeout(8'd1);
        send_event(KIND_RING, 1'b1, 8'h00);
        send_char(CH_LF);
        send_tick();
        set_answer_timeout(8'd0);
        send_event(KIND_RING, 1'b1, 8'h55);
        send_tick();
        set_answer_timeout(8'd2);
        send_event(KIND_RING, 1'b1, 8'hAA);
        send_tick();
        send_tick();
    endtask

    // Calls answered, then response lines mixed with ticks and noise
    task automatic test_random_responses(input logic [7:0] tmo, input int goal,
                                         input int tick_pct, input bit calm,
                                         input bit squeeze);
        int         stop_at;
        logic [7:0] b;
        set_answer_timeout(tmo);
        steady = calm;
        if (squeeze)
            hold_request = 1'b1;
        stop_at = useful_items + goal;
        while (useful_items < stop_at) begin
            if (ph_m == PH_WAIT) begin
                if ($urandom_range(0, 9) < 2) begin
                    send_noise();
                end else begin
                    b = 8'($urandom_range(0, 255));
                    send_event(KIND_RING, 1'b1, b);
                end
            end else if ($urandom_range(0, 99) < 8) begin
                // ticks until the call is given up
                while (ph_m != PH_WAIT) begin
                    if ($urandom_range(0, 19) == 0)
                        send_char(CH_LF);
                    else
                        send_tick();
                end
            end else begin
                repeat ($urandom_range(0, 2)) begin
                    b = 8'($urandom_range(0, 255));
                    send_event(KIND_BYTE, 1'b0, b);
                end
                send_char(CH_LF);
                if ($urandom_range(0, 9) == 0) begin
                    send_char(CH_CR);
                    send_char(CH_LF);
                end
                repeat ($urandom_range(0, 2))
                    send_char(CH_LF);
                send_text(build_line(), tick_pct);
                send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
            end
        end
        wait_quiet();
        steady = 1'b0;
    endtask

    // The one connection of the run, then everything must be ignored
    task automatic test_connect_and_hold();
        string line;
        if (ph_m == PH_WAIT)
            send_event(KIND_RING, 1'b1, 8'h00);
        send_char(CH_LF);
        case ($urandom_range(0, 4))
            0: line = "CONNECT";
            1: begin
                case ($urandom_range(0, 5))
                    0: line = "CONNECT 300";
                    1: line = "CONNECT 600";
                    2: line = "CONNECT 1200";
                    3: line = "CONNECT 2400";
                    4: line = "CONNECT 4800";
                    default: line = "CONNECT 9600";
                endcase
            end
            2: line = $sformatf("CONNECT %0d", $urandom_range(4801, 38400));
            3: begin
                // last digit falls beyond the kept width: 300, not 3000
                line = "CONNECT ";
                repeat (52)
                    line = {line, "0"};
                line = {line, "3000"};
            end
            default: line = "CONNECT/ARQ";
        endcase
        send_text(line, 0);
        send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
        repeat (20)
            send_noise();
        send_event(KIND_RING, 1'b1, 8'h00);
        wait_quiet();
    endtask

    // ------------------------------------------------------------ sequence
    initial begin
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_wait_ring_ignores();
        test_line_hunting();
        test_timeout_edges();
        test_random_responses(8'd3, 400, 3, 1'b0, 1'b1);
        test_random_responses(8'd255, 400, 1, 1'b0, 1'b0);
        test_random_responses(TIMEOUT_RESET, 350, 2, 1'b1, 1'b0);
        test_random_responses(8'($urandom_range(4, 40)), 400, 5, 1'b0, 1'b0);
        test_random_responses(8'd1, 400, 1, 1'b0, 1'b0);
        test_connect_and_hold();

        repeat (5) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            errors++;
            $display("%0t ns: %0d results never arrived", $time, pending_results.size());
        end
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
